### sv/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helpers for the JSON string unescape / UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned CAP_W           = 16;
  localparam logic [CAP_W-1:0] CAP_RESET  = 16'd32;

  // result queue
  localparam int unsigned QDEPTH   = 8;
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
  localparam int unsigned MAX_RES  = 4;

  typedef enum logic [2:0] {
    M_IDLE,
    M_BODY,
    M_ESC,
    M_HEX,
    M_SBS,
    M_SU,
    M_HEXLO
  } mode_t;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_NO_QUOTE   = 4'd1,
    ERR_CTRL_CHAR  = 4'd2,
    ERR_BAD_ESC    = 4'd3,
    ERR_BAD_HEX    = 4'd4,
    ERR_INCOMPLETE = 4'd5,
    ERR_SURROGATE  = 4'd6,
    ERR_TOO_LARGE  = 4'd7,
    ERR_UNTERM     = 4'd8
  } err_t;

  typedef struct packed {
    logic       last;
    logic       fin;
    logic       vld;
    err_t       err;
    logic [7:0] data;
  } rslt_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    return v;
  endfunction

endpackage

### sv/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a quoted JSON string byte by byte into UTF-8 with escape handling,
// surrogate pairs, capacity check and numbered error / finished reports.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                          tuser                 tlast
//  in_      in   [7:0] in_byte                  [0] start_req         -
//  out_     out  [7:0] out_byte [11:8] err_code [0] byte_valid [1] fin last
//  cfg_     in   cfg_wr_data = capacity (16 b)  -                     -
//
//  One input transfer per cycle while in_tready is high; decode is a single
//  combinational pass from the state registers into an 8-entry result queue.
//  An input byte yields 0..4 results; the queue drains one result per cycle
//  while out_tready is high.
//  in_tready is high while the queue holds at most 4 results.
//  rst_n (synchronous) returns the parser to idle, empties the queue and
//  sets capacity to 32.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic [0:0]        in_tuser,   // [0] start_req
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [7:0] out_byte, [11:8] error_code
  output logic [1:0]        out_tuser,  // [0] byte_valid, [1] finished
  output logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data
);

  localparam int unsigned CW = ((LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W) + 1;

  mode_t                  mode_r, mode_nxt;
  logic [1:0]             hcnt_r, hcnt_nxt;
  logic [15:0]            cu_r, cu_nxt;
  logic [9:0]             hs_r, hs_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [CAP_W-1:0]       cap_r;

  rslt_t                  q_r [QDEPTH];
  rslt_t                  q_nxt [QDEPTH];
  logic [QCNT_W-1:0]      cnt_r, cnt_nxt;

  rslt_t                  res [MAX_RES];
  logic [2:0]             nres;

  logic                   in_fire, out_fire;
  logic [7:0]             c;
  logic [4:0]             hv;
  logic [15:0]            cu_new;
  logic [CW-1:0]          cap_eff, cap_ext, cap_lim, len_p1, len_p5;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;
  assign c        = in_tdata;
  assign hv       = hex_val(c);
  assign cu_new   = {cu_r[11:0], hv[3:0]};

  assign cap_ext = CW'(cap_r);
  assign cap_lim = CW'(1) << LENGTH_BITS;
  assign cap_eff = (cap_ext < cap_lim) ? cap_ext : cap_lim;
  assign len_p1  = CW'(len_r) + CW'(1);
  assign len_p5  = CW'(len_r) + CW'(5);

  // decode
  always_comb begin
    err_t        err;
    logic        fin;
    logic        do_plain;
    logic [7:0]  pv;
    logic        do_utf;
    logic [20:0] ch;
    mode_nxt = mode_r;
    hcnt_nxt = hcnt_r;
    cu_nxt   = cu_r;
    hs_nxt   = hs_r;
    len_nxt  = len_r;
    err      = ERR_NONE;
    fin      = 1'b0;
    do_plain = 1'b0;
    pv       = c;
    do_utf   = 1'b0;
    ch       = '0;
    nres     = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end

    if (in_tuser[0]) begin
      hcnt_nxt = '0;
      cu_nxt   = '0;
      hs_nxt   = '0;
      len_nxt  = '0;
      if (c == CH_QUOTE) mode_nxt = M_BODY;
      else err = ERR_NO_QUOTE;
    end else begin
      unique case (mode_r)
        M_BODY: begin
          if (c == 8'h00) err = ERR_UNTERM;
          else if (c == CH_QUOTE) begin
            mode_nxt = M_IDLE;
            fin      = 1'b1;
          end else if (c < 8'h20) err = ERR_CTRL_CHAR;
          else if (c == CH_BSL) mode_nxt = M_ESC;
          else do_plain = 1'b1;
        end
        M_ESC: begin
          do_plain = 1'b1;
          case (c)
            CH_U: begin
              do_plain = 1'b0;
              mode_nxt = M_HEX;
              hcnt_nxt = '0;
              cu_nxt   = '0;
            end
            CH_N: pv = 8'h0a;
            CH_R: pv = 8'h0d;
            CH_T: pv = 8'h09;
            CH_B: pv = 8'h08;
            CH_F: pv = 8'h0c;
            CH_BSL, CH_QUOTE, CH_SLASH: pv = c;
            default: begin
              do_plain = 1'b0;
              err      = ERR_BAD_ESC;
            end
          endcase
        end
        M_HEX, M_HEXLO: begin
          if (c == 8'h00) err = ERR_INCOMPLETE;
          else if (hv[4]) err = ERR_BAD_HEX;
          else begin
            cu_nxt = cu_new;
            if (hcnt_r != 2'd3) hcnt_nxt = hcnt_r + 2'd1;
            else begin
              hcnt_nxt = '0;
              if (mode_r == M_HEXLO) begin
                if (cu_new[15:10] != 6'b110111) err = ERR_SURROGATE;
                else begin
                  do_utf = 1'b1;
                  ch     = 21'h10000 + {1'b0, hs_r, cu_new[9:0]};
                end
              end else if (cu_new[15:10] == 6'b110110) begin
                hs_nxt   = cu_new[9:0];
                mode_nxt = M_SBS;
              end else if (cu_new[15:10] == 6'b110111) err = ERR_SURROGATE;
              else begin
                do_utf = 1'b1;
                ch     = {5'd0, cu_new};
              end
            end
          end
        end
        M_SBS: begin
          if (c == CH_BSL) mode_nxt = M_SU;
          else err = ERR_SURROGATE;
        end
        M_SU: begin
          if (c == CH_U) begin
            mode_nxt = M_HEXLO;
            hcnt_nxt = '0;
            cu_nxt   = '0;
          end else err = ERR_SURROGATE;
        end
        default: mode_nxt = M_IDLE;
      endcase
    end

    if (do_plain) begin
      if (len_p1 >= cap_eff) err = ERR_TOO_LARGE;
      else begin
        len_nxt     = len_r + LENGTH_BITS'(1);
        mode_nxt    = M_BODY;
        nres        = 3'd1;
        res[0].vld  = 1'b1;
        res[0].data = pv;
      end
    end

    if (do_utf) begin
      if (len_p5 >= cap_eff) err = ERR_TOO_LARGE;
      else begin
        mode_nxt = M_BODY;
        for (int k = 0; k < MAX_RES; k++) begin
          res[k].vld = 1'b1;
        end
        if (ch >= 21'h10000) begin
          nres        = 3'd4;
          res[0].data = {5'b11110, ch[20:18]};
          res[1].data = {2'b10, ch[17:12]};
          res[2].data = {2'b10, ch[11:6]};
          res[3].data = {2'b10, ch[5:0]};
        end else if (ch >= 21'h800) begin
          nres        = 3'd3;
          res[0].data = {4'b1110, ch[15:12]};
          res[1].data = {2'b10, ch[11:6]};
          res[2].data = {2'b10, ch[5:0]};
        end else if (ch >= 21'h80) begin
          nres        = 3'd2;
          res[0].data = {3'b110, ch[10:6]};
          res[1].data = {2'b10, ch[5:0]};
        end else begin
          nres        = 3'd1;
          res[0].data = ch[7:0];
        end
        len_nxt = len_r + LENGTH_BITS'(nres);
      end
    end

    if (err != ERR_NONE) begin
      mode_nxt   = M_IDLE;
      nres       = 3'd1;
      res[0]     = '0;
      res[0].err = err;
    end else if (fin) begin
      nres       = 3'd1;
      res[0].fin = 1'b1;
    end

    for (int k = 0; k < MAX_RES; k++) begin
      if (3'(k + 1) == nres) res[k].last = 1'b1;
    end
  end

  // result queue: head at slot 0, shifts on pop, appends behind the tail
  always_comb begin
    logic [QCNT_W-1:0] base;
    logic [QCNT_W-1:0] off;
    base = cnt_r - QCNT_W'(out_fire);
    off  = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      if (out_fire && i < QDEPTH - 1) q_nxt[i] = q_r[i + 1];
      else q_nxt[i] = q_r[i];
    end
    if (in_fire) begin
      for (int i = 0; i < QDEPTH; i++) begin
        off = QCNT_W'(i) - base;
        if (QCNT_W'(i) >= base && off < QCNT_W'(nres)) q_nxt[i] = res[off[1:0]];
      end
      cnt_nxt = base + QCNT_W'(nres);
    end else begin
      cnt_nxt = base;
    end
  end

  assign in_tready  = (cnt_r <= QCNT_W'(QDEPTH - MAX_RES));
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {4'b0000, q_r[0].err, q_r[0].data};
  assign out_tuser  = {q_r[0].fin, q_r[0].vld};
  assign out_tlast  = q_r[0].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      hcnt_r <= '0;
      cu_r   <= '0;
      hs_r   <= '0;
      len_r  <= '0;
      cap_r  <= CAP_RESET;
      cnt_r  <= '0;
    end else begin
      if (in_fire) begin
        mode_r <= mode_nxt;
        hcnt_r <= hcnt_nxt;
        cu_r   <= cu_nxt;
        hs_r   <= hs_nxt;
        len_r  <= len_nxt;
      end
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

### tb/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// Self-checking bench for the JSON string unescape / UTF-8 encoder. Quoted
// strings are streamed in byte by byte under random valid/ready gaps. Most
// strings are well formed with random plain bytes, escapes and \u code points;
// the rest inject faults. A scoreboard predicts every result transfer and
// checks each one in order. Capacity is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  localparam int unsigned LEN_BITS   = LENGTH_BITS_DEF;
  localparam int unsigned ITEM_GOAL  = 320;
  localparam int unsigned N_PHASES   = 6;
  localparam int unsigned SETTLE_CYC = 8;
  localparam int unsigned MAX_PRINTS = 100;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_FF  = 8'h0c;

  localparam logic [15:0] HI_SUR_BASE = 16'hd800;
  localparam logic [15:0] LO_SUR_BASE = 16'hdc00;
  localparam logic [15:0] LO_SUR_TOP  = 16'hdfff;

  typedef enum int unsigned {
    F_CTRL, F_ZERO_ESC, F_BAD_ESC, F_BAD_HEX, F_ZERO_HEX, F_LONE_LOW,
    F_NO_BSL, F_NO_U, F_BAD_LOW, F_RESTART, F_ZERO_BODY
  } fault_kind_t;

  // --------------------------------------------------------------------------
  class utf8_scoreboard;
    mode_t           mode;
    logic [1:0]      hex_cnt;
    logic [15:0]     unit;
    logic [9:0]      hi_sur;
    int unsigned     out_len;
    logic [15:0]     cap;
    rslt_t           exp_q[$];
    rslt_t           step_q[$];
    int unsigned     errors;

    function new();
      mode    = M_IDLE;
      hex_cnt = '0;
      unit    = '0;
      hi_sur  = '0;
      out_len = 0;
      cap     = CAP_RESET;
      errors  = 0;
    endfunction

    function void flag_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function logic [4:0] nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      return 5'h10;
    endfunction

    function void add(logic [7:0] d, logic v, logic f, err_t e);
      rslt_t r;
      r.data = d;
      r.vld  = v;
      r.fin  = f;
      r.err  = e;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function void fault(err_t e);
      mode = M_IDLE;
      add(8'h00, 1'b0, 1'b0, e);
    endfunction

    function longint unsigned cap_limit();
      longint unsigned lim;
      lim = longint'(1) << LEN_BITS;
      return (longint'(cap) < lim) ? longint'(cap) : lim;
    endfunction

    function void put_plain(logic [7:0] c);
      if (longint'(out_len) + 1 >= cap_limit()) begin
        fault(ERR_TOO_LARGE);
      end else begin
        out_len++;
        mode = M_BODY;
        add(c, 1'b1, 1'b0, ERR_NONE);
      end
    endfunction

    function void put_utf8(int unsigned ch);
      if (longint'(out_len) + 5 >= cap_limit()) begin
        fault(ERR_TOO_LARGE);
        return;
      end
      if (ch >= 32'h10000) add(8'hf0 | 8'(ch >> 18), 1'b1, 1'b0, ERR_NONE);
      if (ch >= 32'h800)
        add(((ch >= 32'h10000) ? 8'h80 : 8'he0) | 8'((ch >> 12) & 63), 1'b1, 1'b0, ERR_NONE);
      if (ch >= 32'h80)
        add(((ch >= 32'h800) ? 8'h80 : 8'hc0) | 8'((ch >> 6) & 63), 1'b1, 1'b0, ERR_NONE);
      add((ch >= 32'h80) ? (8'h80 | 8'(ch & 63)) : 8'(ch), 1'b1, 1'b0, ERR_NONE);
      out_len += step_q.size();
      mode = M_BODY;
    endfunction

    function void take_hex(logic [7:0] c, bit low_half);
      logic [4:0]  d;
      int unsigned cp;
      if (c == CH_NUL) begin
        fault(ERR_INCOMPLETE);
        return;
      end
      d = nibble_of(c);
      if (d[4]) begin
        fault(ERR_BAD_HEX);
        return;
      end
      unit = {unit[11:0], d[3:0]};
      if (hex_cnt < 2'd3) begin
        hex_cnt++;
        return;
      end
      hex_cnt = '0;
      if (low_half) begin
        if (unit < LO_SUR_BASE || unit > LO_SUR_TOP) begin
          fault(ERR_SURROGATE);
        end else begin
          cp = 32'h10000 + ({22'd0, hi_sur} << 10) + {16'd0, unit} - {16'd0, LO_SUR_BASE};
          put_utf8(cp);
        end
      end else if (unit >= HI_SUR_BASE && unit < LO_SUR_BASE) begin
        hi_sur = 10'(unit - HI_SUR_BASE);
        mode   = M_SBS;
      end else if (unit >= LO_SUR_BASE && unit <= LO_SUR_TOP) begin
        fault(ERR_SURROGATE);
      end else begin
        put_utf8({16'd0, unit});
      end
    endfunction

    // notes one accepted input transfer
    function void accept_byte(logic [7:0] c, logic s);
      rslt_t r;
      step_q.delete();
      if (s) begin
        hex_cnt = '0;
        unit    = '0;
        hi_sur  = '0;
        out_len = 0;
        if (c == CH_QUOTE) mode = M_BODY;
        else fault(ERR_NO_QUOTE);
      end else begin
        case (mode)
          M_BODY: begin
            if (c == CH_NUL) fault(ERR_UNTERM);
            else if (c == CH_QUOTE) begin
              mode = M_IDLE;
              add(8'h00, 1'b0, 1'b1, ERR_NONE);
            end else if (c < 8'h20) fault(ERR_CTRL_CHAR);
            else if (c == CH_BSL) mode = M_ESC;
            else put_plain(c);
          end
          M_ESC: begin
            if (c == CH_U) begin
              mode    = M_HEX;
              hex_cnt = '0;
              unit    = '0;
            end else if (c == CH_N) put_plain(CH_LF);
            else if (c == CH_R) put_plain(CH_CR);
            else if (c == CH_T) put_plain(CH_TAB);
            else if (c == CH_B) put_plain(CH_BS);
            else if (c == CH_F) put_plain(CH_FF);
            else if (c == CH_BSL || c == CH_QUOTE || c == CH_SLASH) put_plain(c);
            else fault(ERR_BAD_ESC);
          end
          M_HEX: take_hex(c, 1'b0);
          M_SBS: begin
            if (c == CH_BSL) mode = M_SU;
            else fault(ERR_SURROGATE);
          end
          M_SU: begin
            if (c == CH_U) begin
              mode    = M_HEXLO;
              hex_cnt = '0;
              unit    = '0;
            end else fault(ERR_SURROGATE);
          end
          M_HEXLO: take_hex(c, 1'b1);
          default: mode = M_IDLE;
        endcase
      end
      foreach (step_q[i]) begin
        r      = step_q[i];
        r.last = (i == step_q.size() - 1);
        exp_q.push_back(r);
      end
    endfunction

    function void check_output(rslt_t got);
      rslt_t want;
      if (exp_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result byte=%02h err=%0d vld=%b fin=%b last=%b",
                                got.data, got.err, got.vld, got.fin, got.last));
        return;
      end
      want = exp_q.pop_front();
      if (got.data !== want.data || got.err !== want.err || got.vld !== want.vld ||
          got.fin !== want.fin || got.last !== want.last)
        flag_mismatch($sformatf("got byte=%02h err=%0d vld=%b fin=%b last=%b, want %02h %0d %b %b %b",
                                got.data, got.err, got.vld, got.fin, got.last,
                                want.data, want.err, want.vld, want.fin, want.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;   // [7:0] in_byte
  logic [0:0]  in_tuser    = '0;   // [0] start_req
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // [7:0] out_byte, [11:8] error_code
  logic [1:0]  out_tuser;          // [0] byte_valid, [1] finished
  logic        out_tlast;
  logic        cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  utf8_scoreboard sb = new();
  int unsigned    gap_pct    = 34;
  int unsigned    sent_items = 0;

  json_string_unescape_utf8 u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: check every transfer, random backpressure
  initial begin
    rslt_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.data = out_tdata[7:0];
        got.err  = err_t'(out_tdata[11:8]);
        got.vld  = out_tuser[0];
        got.fin  = out_tuser[1];
        got.last = out_tlast;
        sb.check_output(got);
      end
      out_tready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    do @(posedge clk); while (!in_tready);
    sb.accept_byte(b, s);
    sent_items++;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return (($urandom_range(1) != 0) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  task automatic send_u_escape(input logic [15:0] v);
    send_byte(CH_BSL, 1'b0);
    send_byte(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(v[4*i +: 4]), 1'b0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.cap = v;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_fault();
    fault_kind_t kind;
    logic [7:0]  c;
    int unsigned k;
    kind = fault_kind_t'($urandom_range(F_ZERO_BODY));
    k    = $urandom_range(3);
    case (kind)
      F_CTRL:     send_byte(8'($urandom_range(1, 31)), 1'b0);
      F_ZERO_ESC: begin
        send_byte(CH_BSL, 1'b0);
        send_byte(CH_NUL, 1'b0);
      end
      F_BAD_ESC: begin
        do c = 8'($urandom_range(1, 255));
        while (c == CH_U || c == CH_N || c == CH_R || c == CH_T || c == CH_B ||
               c == CH_F || c == CH_BSL || c == CH_QUOTE || c == CH_SLASH);
        send_byte(CH_BSL, 1'b0);
        send_byte(c, 1'b0);
      end
      F_BAD_HEX, F_ZERO_HEX: begin
        send_byte(CH_BSL, 1'b0);
        send_byte(CH_U, 1'b0);
        repeat (k) send_byte(hex_char(4'($urandom_range(15))), 1'b0);
        if (kind == F_ZERO_HEX) begin
          send_byte(CH_NUL, 1'b0);
        end else begin
          do c = 8'($urandom_range(1, 255)); while (sb.nibble_of(c) < 5'd16);
          send_byte(c, 1'b0);
        end
      end
      F_LONE_LOW: send_u_escape(LO_SUR_BASE + 16'($urandom_range(16'h3ff)));
      F_NO_BSL: begin
        send_u_escape(HI_SUR_BASE + 16'($urandom_range(16'h3ff)));
        do c = 8'($urandom_range(255)); while (c == CH_BSL);
        send_byte(c, 1'b0);
      end
      F_NO_U: begin
        send_u_escape(HI_SUR_BASE + 16'($urandom_range(16'h3ff)));
        send_byte(CH_BSL, 1'b0);
        do c = 8'($urandom_range(255)); while (c == CH_U);
        send_byte(c, 1'b0);
      end
      F_BAD_LOW: begin
        send_u_escape(HI_SUR_BASE + 16'($urandom_range(16'h3ff)));
        send_u_escape(16'($urandom_range(16'hdbff)));
      end
      F_RESTART:   send_byte(CH_QUOTE, 1'b1);
      F_ZERO_BODY: send_byte(CH_NUL, 1'b0);
      default:     send_byte(CH_NUL, 1'b0);
    endcase
  endtask

  task automatic send_random_string(input int unsigned max_len);
    logic [7:0]  esc_set [8];
    logic [7:0]  c;
    logic [15:0] cp;
    int unsigned len;
    int unsigned pick;
    bit          broken;
    esc_set = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_BSL, CH_QUOTE, CH_SLASH};
    if ($urandom_range(24) == 0) begin
      c = 8'($urandom_range(255));
      send_byte(c, 1'b1);
      if (c != CH_QUOTE) return;
    end else begin
      send_byte(CH_QUOTE, 1'b1);
    end
    len    = ($urandom_range(7) == 0) ? $urandom_range(max_len) : $urandom_range(10);
    broken = 1'b0;
    for (int i = 0; i < len && !broken; i++) begin
      pick = $urandom_range(199);
      if (pick < 100) begin
        do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSL);
        send_byte(c, 1'b0);
      end else if (pick < 130) begin
        send_byte(CH_BSL, 1'b0);
        send_byte(esc_set[$urandom_range(7)], 1'b0);
      end else if (pick < 155) begin
        cp = 16'($urandom_range(16'hffff));
        if (cp >= HI_SUR_BASE && cp <= LO_SUR_TOP) cp = cp ^ 16'h8000;
        if ($urandom_range(2) == 0) cp = cp & 16'h07ff;
        send_u_escape(cp);
      end else if (pick < 175) begin
        send_u_escape(HI_SUR_BASE + 16'($urandom_range(16'h3ff)));
        send_u_escape(LO_SUR_BASE + 16'($urandom_range(16'h3ff)));
      end else begin
        send_fault();
        broken = (sb.mode == M_IDLE);
      end
    end
    if (!broken) send_byte(($urandom_range(19) == 0) ? CH_NUL : CH_QUOTE, 1'b0);
    if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // --------------------------------------------------------------------------
  initial begin
    logic [CAP_W-1:0] caps [N_PHASES];
    int unsigned      phase_goal;
    caps = '{16'd32, 16'd2, 16'hffff, 16'd12, 16'($urandom_range(3, 64)), 16'd48};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle byte, bad start, extremes, \u0000, max code point, NUL escape
    send_byte("x", 1'b0);
    send_byte(CH_NUL, 1'b1);
    send_byte(CH_QUOTE, 1'b1);
    send_byte(8'hff, 1'b0);
    send_u_escape(16'h0000);
    send_u_escape(16'hdbff);
    send_u_escape(16'hdfff);
    send_byte(CH_BSL, 1'b0);
    send_byte(CH_NUL, 1'b0);

    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(caps[p]);
      gap_pct    = (p == 2) ? 0 : 34;
      phase_goal = ITEM_GOAL * (p + 1) / N_PHASES;
      do send_random_string((caps[p] > 16'd40) ? 40 : int'(caps[p]) + 6);
      while (sent_items < phase_goal);
    end

    wait_drained();
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
